/* design/magnetometer_minmax_calibrator_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the magnetometer min/max calibrator
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_MINMAX_CALIBRATOR_CORE_DEFINES_SVH
`define MAGNETOMETER_MINMAX_CALIBRATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define MMC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MMC_ASSERT(label, prop, msg)
`define MMC_NEVER(label, cond, msg)
`endif

`endif

/* design/mmcal_pkg.sv */
// ----------------------------------------------------------------------------
// Magnetometer calibrator package
// Shared widths, codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcal_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int QUOT_BITS     = 32;
	localparam int OUT_W         = 16;

	// Centered value n = 2*s - min - max and its magnitude.
	localparam int N_W    = SAMPLE_BITS + 2;
	localparam int AN_W   = SAMPLE_BITS + 1;
	localparam int D_W    = SAMPLE_BITS + 1;
	// First quotient round(|n| * 2^32 / |d|).
	localparam int DVD_W  = AN_W + QUOT_BITS + 1;
	localparam int CNT_W  = 6;
	// Normalized magnitudes lie in [2^29, 2^30).
	localparam int NRM_HI = 30;
	localparam int NRM_LO = 29;
	localparam int SUM_W  = 2 * NRM_HI + 2;
	localparam int ROOT_W = NRM_HI + 1;
	// Final divide: (q << OUT_FRAC_BITS) + norm/2 over norm.
	localparam int UNUM_W = NRM_HI + OUT_FRAC_BITS + 1;
	localparam int UQ_W   = UNUM_W - NRM_LO;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [1:0] MODE_PRESET  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CALIB_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PMIN_X   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PMIN_Y   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PMIN_Z   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PMAX_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PMAX_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PMAX_Z   = 3'd6;

	localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_X = -16'sd317;
	localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_Y = -16'sd416;
	localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_Z = -16'sd208;
	localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_X = 16'sd221;
	localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_Y = -16'sd67;
	localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_Z = 16'sd98;

	// One sample handed from the front to the back.
	typedef struct packed {
		logic [2:0][AN_W-1:0] an;
		logic [2:0][D_W-1:0]  ad;
		logic [2:0]           neg;
	} entry_t;

endpackage

`default_nettype wire

/* design/magnetometer_minmax_calibrator_core.sv */
// A sample transaction passes through the per-axis divide, the normalizing shifts, squaring,
// the square root and the final divide, plus handoff states, before its result is registered.
// A zero vector skips the squaring, root and final divide and goes straight to the output state.
// The single back-end sequencer takes one sample at a time, the next only once the last is done;
// bound-update transactions (modes 1 and 2) and mode 3 return nothing.
// ----------------------------------------------------------------------------
// Magnetometer min/max calibrator core
// Front end for bounds and classification, a two-entry queue, and an
// iterative arithmetic back end producing a calibrated Q1.14 unit vector.
// Reset: arst_n clears all registers but the queue storage; bounds and presets take their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_minmax_calibrator_core (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic [1:0]                               mode,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_x,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_y,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_z,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [mmcal_pkg::OUT_W-1:0]            unit_x,
	output logic signed [mmcal_pkg::OUT_W-1:0]            unit_y,
	output logic signed [mmcal_pkg::OUT_W-1:0]            unit_z,
	output logic                                          zero_length,
	input  wire logic                                     cfg_valid,
	output logic                                          cfg_ready,
	input  wire logic [mmcal_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [mmcal_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import mmcal_pkg::*;

	logic   push, full, pop, empty;
	entry_t push_data, pop_data;

	// Input side: configuration, bounds and centering.
	mmcal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.mag_z     (mag_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decoupling queue.
	mmcal_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Arithmetic and output register.
	mmcal_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.zero_length (zero_length)
	);

endmodule

`default_nettype wire

/* design/mmcal_front.sv */
// ----------------------------------------------------------------------------
// Calibrator front end
// Accepts input transactions, holds configuration and the per-axis bounds,
// and turns each sample into centered magnitudes for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcal_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           mode,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_x,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_y,
	input  wire logic signed [mmcal_pkg::SAMPLE_BITS-1:0] mag_z,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mmcal_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mmcal_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                      push,
	output mmcal_pkg::entry_t                         push_data,
	input  wire logic                                 full
);
	import mmcal_pkg::*;

	logic                          calib_en_q;
	logic signed [SAMPLE_BITS-1:0] pmin_q [3];
	logic signed [SAMPLE_BITS-1:0] pmax_q [3];
	logic signed [SAMPLE_BITS-1:0] min_q  [3];
	logic signed [SAMPLE_BITS-1:0] max_q  [3];
	logic signed [SAMPLE_BITS-1:0] smp    [3];
	logic signed [SAMPLE_BITS-1:0] new_min [3];
	logic signed [SAMPLE_BITS-1:0] new_max [3];
	logic                          accept;

	assign in_stall  = full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign push      = accept && (mode == MODE_SAMPLE);

	assign smp[0] = mag_x;
	assign smp[1] = mag_y;
	assign smp[2] = mag_z;

	// Widened bounds and centered magnitudes for each axis.
	always_comb begin
		logic signed [N_W-1:0] n;
		logic signed [D_W-1:0] d;
		for (int i = 0; i < 3; i++) begin
			new_min[i] = (calib_en_q && (smp[i] < min_q[i])) ? smp[i] : min_q[i];
			new_max[i] = (calib_en_q && (smp[i] > max_q[i])) ? smp[i] : max_q[i];
			n = $signed({smp[i][SAMPLE_BITS-1], smp[i], 1'b0})
				- $signed({{2{new_min[i][SAMPLE_BITS-1]}}, new_min[i]})
				- $signed({{2{new_max[i][SAMPLE_BITS-1]}}, new_max[i]});
			d = $signed({new_max[i][SAMPLE_BITS-1], new_max[i]})
				- $signed({new_min[i][SAMPLE_BITS-1], new_min[i]});
			if (d == '0) begin
				d = D_W'(2);
			end
			push_data.an[i]  = n[N_W-1] ? AN_W'(-n) : AN_W'(n);
			push_data.ad[i]  = d[D_W-1] ? D_W'(-d) : D_W'(d);
			push_data.neg[i] = n[N_W-1] != d[D_W-1];
		end
	end

	// Configuration registers and bound storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_en_q <= 1'b0;
			pmin_q[0] <= RST_MIN_X; pmin_q[1] <= RST_MIN_Y; pmin_q[2] <= RST_MIN_Z;
			pmax_q[0] <= RST_MAX_X; pmax_q[1] <= RST_MAX_Y; pmax_q[2] <= RST_MAX_Z;
			min_q[0]  <= RST_MIN_X; min_q[1]  <= RST_MIN_Y; min_q[2]  <= RST_MIN_Z;
			max_q[0]  <= RST_MAX_X; max_q[1]  <= RST_MAX_Y; max_q[2]  <= RST_MAX_Z;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CALIB_EN: calib_en_q <= cfg_data[0];
					REG_PMIN_X:   pmin_q[0] <= $signed(cfg_data);
					REG_PMIN_Y:   pmin_q[1] <= $signed(cfg_data);
					REG_PMIN_Z:   pmin_q[2] <= $signed(cfg_data);
					REG_PMAX_X:   pmax_q[0] <= $signed(cfg_data);
					REG_PMAX_Y:   pmax_q[1] <= $signed(cfg_data);
					REG_PMAX_Z:   pmax_q[2] <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (accept) begin
				case (mode)
					MODE_SAMPLE: begin
						for (int i = 0; i < 3; i++) begin
							min_q[i] <= new_min[i];
							max_q[i] <= new_max[i];
						end
					end
					MODE_PRESET: begin
						for (int i = 0; i < 3; i++) begin
							min_q[i] <= pmin_q[i];
							max_q[i] <= pmax_q[i];
						end
					end
					MODE_RESTART: begin
						for (int i = 0; i < 3; i++) begin
							min_q[i] <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
							max_q[i] <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* design/mmcal_queue.sv */
// ----------------------------------------------------------------------------
// Calibrator sample queue
// Short FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "magnetometer_minmax_calibrator_core_defines.svh"

module mmcal_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire mmcal_pkg::entry_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output mmcal_pkg::entry_t      pop_data,
	output logic                   empty
);
	import mmcal_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`MMC_NEVER(a_no_overflow, push && full, "queue written while full")
	`MMC_NEVER(a_no_underflow, pop && empty, "queue read while empty")
	`MMC_ASSERT(a_count_bound, count_q <= (PTR_W+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

/* design/mmcal_back.sv */
// ----------------------------------------------------------------------------
// Calibrator arithmetic back end
// Per-axis restoring divide, common normalizing shift, sum of squares,
// digit-by-digit square root and a final divide into a Q1.14 vector.
// ----------------------------------------------------------------------------
`default_nettype none
`include "magnetometer_minmax_calibrator_core_defines.svh"

module mmcal_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  empty,
	input  wire mmcal_pkg::entry_t                     pop_data,
	output logic                                       pop,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [mmcal_pkg::OUT_W-1:0]         unit_x,
	output logic signed [mmcal_pkg::OUT_W-1:0]         unit_y,
	output logic signed [mmcal_pkg::OUT_W-1:0]         unit_z,
	output logic                                       zero_length
);
	import mmcal_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_NORM, ST_SQR, ST_SQRT, ST_UINIT, ST_UDIV, ST_DONE
	} state_t;

	localparam logic [UQ_W-1:0] ONE = UQ_W'(1) << OUT_FRAC_BITS;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  dvd_q  [3];
	logic [D_W-1:0]    ad_q   [3];
	logic [D_W-1:0]    rem_q  [3];
	logic [DVD_W-1:0]  q_q    [3];
	logic [2:0]        neg_q;
	logic              zero_q;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  x_q;
	logic [SUM_W-1:0]  r_q;
	logic [SUM_W-1:0]  bit_q;
	logic [ROOT_W-1:0] norm_q;
	logic [ROOT_W-1:0] urem_q [3];
	logic [UQ_W-1:0]   ulow_q [3];
	logic [UQ_W-1:0]   uq_q   [3];
	logic              out_valid_q;
	logic signed [OUT_W-1:0] unit_x_q, unit_y_q, unit_z_q;
	logic              zero_len_q;

	logic [D_W-1:0]    rem_nx  [3];
	logic              qbit_nx [3];
	logic [ROOT_W-1:0] urem_nx [3];
	logic              ubit_nx [3];
	logic [NRM_HI-1:0] sq_op;
	logic [2*NRM_HI-1:0] sq_full;
	logic [SUM_W-1:0]  sq_prod;
	logic [SUM_W-1:0]  sq_trial;
	logic [OUT_W-1:0]  umag [3];
	logic              any_hi, any_lo, all_zero;

	assign pop         = (state_q == ST_IDLE) && !empty;
	assign out_valid   = out_valid_q;
	assign unit_x      = unit_x_q;
	assign unit_y      = unit_y_q;
	assign unit_z      = unit_z_q;
	assign zero_length = zero_len_q;

	// One restoring step per lane for both dividers.
	always_comb begin
		logic [D_W:0]    trial;
		logic [ROOT_W:0] utrial;
		for (int i = 0; i < 3; i++) begin
			trial      = {rem_q[i], dvd_q[i][DVD_W-1]};
			qbit_nx[i] = trial >= {1'b0, ad_q[i]};
			rem_nx[i]  = qbit_nx[i] ? D_W'(trial - {1'b0, ad_q[i]}) : D_W'(trial);
			utrial     = {urem_q[i], ulow_q[i][UQ_W-1]};
			ubit_nx[i] = utrial >= {1'b0, norm_q};
			urem_nx[i] = ubit_nx[i] ? ROOT_W'(utrial - {1'b0, norm_q}) : ROOT_W'(utrial);
			umag[i]    = (uq_q[i] > ONE) ? ONE : uq_q[i];
		end
	end

	// Normalization tests across the three magnitudes.
	always_comb begin
		any_hi   = 1'b0;
		any_lo   = 1'b0;
		all_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			any_hi   = any_hi | (|q_q[i][DVD_W-1:NRM_HI]);
			any_lo   = any_lo | q_q[i][NRM_LO];
			all_zero = all_zero & ~(|q_q[i]);
		end
	end

	// Shared squaring multiplier and square root trial value.
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_op = q_q[0][NRM_HI-1:0];
			2'd1:    sq_op = q_q[1][NRM_HI-1:0];
			2'd2:    sq_op = q_q[2][NRM_HI-1:0];
			default: sq_op = '0;
		endcase
		sq_full  = sq_op * sq_op;
		sq_prod  = SUM_W'(sq_full);
		sq_trial = r_q + bit_q;
	end

	// Sequencer with all datapath and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			unit_x_q    <= '0;
			unit_y_q    <= '0;
			unit_z_q    <= '0;
			zero_len_q  <= 1'b0;
			neg_q       <= '0;
			zero_q      <= 1'b0;
			acc_q       <= '0;
			x_q         <= '0;
			r_q         <= '0;
			bit_q       <= '0;
			norm_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				dvd_q[i]  <= '0;
				ad_q[i]   <= '0;
				rem_q[i]  <= '0;
				q_q[i]    <= '0;
				urem_q[i] <= '0;
				ulow_q[i] <= '0;
				uq_q[i]   <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						for (int i = 0; i < 3; i++) begin
							dvd_q[i] <= DVD_W'({pop_data.an[i], QUOT_BITS'(0)})
								+ DVD_W'(pop_data.ad[i] >> 1);
							ad_q[i]  <= pop_data.ad[i];
							rem_q[i] <= '0;
							q_q[i]   <= '0;
						end
						neg_q   <= pop_data.neg;
						zero_q  <= 1'b0;
						cnt_q   <= CNT_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= rem_nx[i];
						dvd_q[i] <= dvd_q[i] << 1;
						q_q[i]   <= {q_q[i][DVD_W-2:0], qbit_nx[i]};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (all_zero) begin
						zero_q  <= 1'b1;
						state_q <= ST_DONE;
					end else if (any_hi) begin
						for (int i = 0; i < 3; i++) begin
							q_q[i] <= q_q[i] >> 1;
						end
					end else if (!any_lo) begin
						for (int i = 0; i < 3; i++) begin
							q_q[i] <= q_q[i] << 1;
						end
					end else begin
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					acc_q <= acc_q + sq_prod;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2)) begin
						x_q     <= acc_q + sq_prod;
						r_q     <= '0;
						bit_q   <= SUM_W'(1) << (2 * (ROOT_W - 1));
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (x_q >= sq_trial) begin
						x_q <= x_q - sq_trial;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_UINIT;
					end
				end
				ST_UINIT: begin
					norm_q <= r_q[ROOT_W-1:0];
					for (int i = 0; i < 3; i++) begin
						logic [UNUM_W-1:0] num;
						num = UNUM_W'({q_q[i][NRM_HI-1:0], OUT_FRAC_BITS'(0)})
							+ UNUM_W'(r_q[ROOT_W-1:0] >> 1);
						urem_q[i] <= ROOT_W'(num[UNUM_W-1:UQ_W]);
						ulow_q[i] <= num[UQ_W-1:0];
						uq_q[i]   <= '0;
					end
					cnt_q   <= CNT_W'(UQ_W - 1);
					state_q <= ST_UDIV;
				end
				ST_UDIV: begin
					for (int i = 0; i < 3; i++) begin
						urem_q[i] <= urem_nx[i];
						ulow_q[i] <= ulow_q[i] << 1;
						uq_q[i]   <= {uq_q[i][UQ_W-2:0], ubit_nx[i]};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						if (zero_q) begin
							unit_x_q <= '0;
							unit_y_q <= '0;
							unit_z_q <= '0;
						end else begin
							// Axis remap to (y, -x, -z).
							unit_x_q <= neg_q[1] ? -$signed(umag[1]) : $signed(umag[1]);
							unit_y_q <= neg_q[0] ? $signed(umag[0]) : -$signed(umag[0]);
							unit_z_q <= neg_q[2] ? $signed(umag[2]) : -$signed(umag[2]);
						end
						zero_len_q  <= zero_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MMC_ASSERT(a_zero_result, out_valid_q && zero_len_q |-> (unit_x_q == '0 && unit_y_q == '0 && unit_z_q == '0), "zero-length result with nonzero unit fields")
	`MMC_ASSERT(a_norm_window, (state_q == ST_SQR) |-> (!any_hi && any_lo), "magnitudes left normalization window")
	`MMC_ASSERT(a_root_range, (state_q == ST_UDIV) |-> (norm_q[ROOT_W-1] || norm_q[ROOT_W-2]), "vector length below normalized range")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the magnetometer min/max calibrator core
// Drives sample and bound-update transactions with random gaps and stalls,
// writes the calibration registers between phases, and checks every unit
// vector against a bit-exact prediction held in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import mmcal_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic signed [OUT_W-1:0] ux;
		logic signed [OUT_W-1:0] uy;
		logic signed [OUT_W-1:0] uz;
		logic                    zl;
	} unit_vec_t;

	// Calibration model and queue of expected unit vectors.
	class calib_scoreboard;
		bit                 calib_en;
		longint             preset_lo[3];
		longint             preset_hi[3];
		longint             bound_lo[3];
		longint             bound_hi[3];
		unit_vec_t          pending_vecs[$];
		int                 mismatches;
		int                 samples;
		int                 checked;
		int                 zero_vecs;

		function new();
			calib_en = 0;
			preset_lo = '{-317, -416, -208};
			preset_hi = '{221, -67, 98};
			bound_lo = preset_lo;
			bound_hi = preset_hi;
			mismatches = 0;
			samples = 0;
			checked = 0;
			zero_vecs = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_CALIB_EN) begin
				calib_en = data[0];
			end else if (idx >= REG_PMIN_X && idx <= REG_PMIN_Z) begin
				preset_lo[idx - REG_PMIN_X] = longint'($signed(data));
			end else if (idx >= REG_PMAX_X && idx <= REG_PMAX_Z) begin
				preset_hi[idx - REG_PMAX_X] = longint'($signed(data));
			end
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Apply one accepted input transaction and queue its expected result.
		function void note_input(logic [1:0] md, logic signed [SAMPLE_BITS-1:0] sx,
				logic signed [SAMPLE_BITS-1:0] sy, logic signed [SAMPLE_BITS-1:0] sz);
			longint          s[3];
			longint          n;
			longint          d;
			longint unsigned an;
			longint unsigned ad;
			longint unsigned q[3];
			longint unsigned mx;
			longint unsigned nrm;
			longint unsigned v;
			longint          u[3];
			bit              neg[3];
			unit_vec_t       e;
			if (md == MODE_PRESET) begin
				bound_lo = preset_lo;
				bound_hi = preset_hi;
				return;
			end
			if (md == MODE_RESTART) begin
				for (int i = 0; i < 3; i++) begin
					bound_lo[i] = 32767;
					bound_hi[i] = -32768;
				end
				return;
			end
			if (md == MODE_UNUSED) return;
			samples++;
			s = '{longint'(sx), longint'(sy), longint'(sz)};
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				if (calib_en) begin
					if (s[i] < bound_lo[i]) bound_lo[i] = s[i];
					if (s[i] > bound_hi[i]) bound_hi[i] = s[i];
				end
				n = 2 * s[i] - bound_lo[i] - bound_hi[i];
				d = bound_hi[i] - bound_lo[i];
				if (d == 0) d = 2;
				an = (n < 0) ? -n : n;
				ad = (d < 0) ? -d : d;
				q[i] = ((an << QUOT_BITS) + ad / 2) / ad;
				neg[i] = (n < 0) != (d < 0);
				if (q[i] > mx) mx = q[i];
			end
			if (mx == 0) begin
				e = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
				pending_vecs.push_back(e);
				return;
			end
			// Common shift so the largest magnitude lands in [2^29, 2^30).
			while (mx >= (64'd1 << NRM_HI)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) q[i] = q[i] >> 1;
			end
			while (mx < (64'd1 << NRM_LO)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) q[i] = q[i] << 1;
			end
			nrm = int_sqrt(q[0] * q[0] + q[1] * q[1] + q[2] * q[2]);
			if (nrm == 0) nrm = 1;
			for (int i = 0; i < 3; i++) begin
				v = ((q[i] << OUT_FRAC_BITS) + nrm / 2) / nrm;
				if (v > (64'd1 << OUT_FRAC_BITS)) v = 64'd1 << OUT_FRAC_BITS;
				u[i] = neg[i] ? -longint'(v) : longint'(v);
			end
			e.ux = u[1][OUT_W-1:0];
			e.uy = OUT_W'(-u[0]);
			e.uz = OUT_W'(-u[2]);
			e.zl = 1'b0;
			pending_vecs.push_back(e);
		endfunction

		// Compare one accepted result with the oldest expected vector.
		function void check_result(unit_vec_t got);
			unit_vec_t e;
			if (pending_vecs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %0d %0d %0d zl=%0b",
						got.ux, got.uy, got.uz, got.zl);
				return;
			end
			e = pending_vecs.pop_front();
			checked++;
			if (got.zl) zero_vecs++;
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d exp (%0d %0d %0d zl=%0b) got (%0d %0d %0d zl=%0b)",
						checked, e.ux, e.uy, e.uz, e.zl, got.ux, got.uy, got.uz, got.zl);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    mode = MODE_SAMPLE;
	logic signed [SAMPLE_BITS-1:0] mag_x = '0;
	logic signed [SAMPLE_BITS-1:0] mag_y = '0;
	logic signed [SAMPLE_BITS-1:0] mag_z = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [OUT_W-1:0]       unit_x;
	logic signed [OUT_W-1:0]       unit_y;
	logic signed [OUT_W-1:0]       unit_z;
	logic                          zero_length;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	calib_scoreboard sb = new();
	int              idle_cycles = 0;

	magnetometer_minmax_calibrator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .zero_length(zero_length),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stall before each result, then accept and check.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, 13);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result('{ux: unit_x, uy: unit_y, uz: unit_z, zl: zero_length});
		end
	end

	task automatic send_item(logic [1:0] md, logic signed [SAMPLE_BITS-1:0] sx,
			logic signed [SAMPLE_BITS-1:0] sy, logic signed [SAMPLE_BITS-1:0] sz);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		mag_x <= sx;
		mag_y <= sy;
		mag_z <= sz;
		do @(posedge clk); while (in_stall);
		sb.note_input(md, sx, sy, sz);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected result has come and the back end is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_vecs.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_bounds(logic signed [15:0] lx, logic signed [15:0] ly,
			logic signed [15:0] lz, logic signed [15:0] hx, logic signed [15:0] hy,
			logic signed [15:0] hz);
		write_reg(REG_PMIN_X, lx);
		write_reg(REG_PMIN_Y, ly);
		write_reg(REG_PMIN_Z, lz);
		write_reg(REG_PMAX_X, hx);
		write_reg(REG_PMAX_Y, hy);
		write_reg(REG_PMAX_Z, hz);
	endtask

	function automatic logic signed [15:0] rand_sample(int kind);
		case (kind)
			0: rand_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: rand_sample = $signed(16'($urandom_range(0, 1023)) - 16'd512);
			default: rand_sample = 16'($urandom());
		endcase
	endfunction

	initial begin
		int phase_kind;
		int kind;
		int r;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] lo[3];
		logic signed [15:0] hi[3];

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset bounds, field extremes and the special cases.
		send_item(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh0000);
		send_item(MODE_SAMPLE, 16'sh8000, 16'sh7fff, 16'shffff);
		send_item(MODE_SAMPLE, -16'sd48, -16'sd241, -16'sd55);
		send_item(MODE_UNUSED, 16'sh1234, 16'sh4321, 16'sh7fff);
		send_item(MODE_SAMPLE, 16'sd1, 16'sd2, 16'sd3);
		// Restart without sampling leaves the bounds inverted.
		send_item(MODE_RESTART, 16'sh0, 16'sh0, 16'sh0);
		send_item(MODE_SAMPLE, 16'sd100, -16'sd200, 16'sd300);
		send_item(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh7fff);
		drain();
		// Symmetric presets give a zero vector at the origin.
		write_bounds(-16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 16'sd10);
		write_reg(REG_CALIB_EN, 16'd0);
		send_item(MODE_PRESET, 16'sh0, 16'sh0, 16'sh0);
		send_item(MODE_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
		send_item(MODE_SAMPLE, 16'sd10, -16'sd10, 16'sd0);
		send_item(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd5);
		drain();
		// Equal bounds use a half-span of one; extreme presets follow.
		write_bounds(16'sd5, -16'sd3, 16'sh7fff, 16'sd5, -16'sd3, 16'sh7fff);
		send_item(MODE_PRESET, 16'sh0, 16'sh0, 16'sh0);
		send_item(MODE_SAMPLE, 16'sd5, -16'sd3, 16'sh7fff);
		send_item(MODE_SAMPLE, 16'sd6, -16'sd3, 16'sh7fff);
		send_item(MODE_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh8000);
		drain();
		write_bounds(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		write_reg(REG_CALIB_EN, 16'd1);
		send_item(MODE_PRESET, 16'sh0, 16'sh0, 16'sh0);
		send_item(MODE_SAMPLE, 16'sh7fff, 16'sh8000, 16'shffff);
		send_item(MODE_RESTART, 16'sh0, 16'sh0, 16'sh0);
		send_item(MODE_SAMPLE, 16'sd7, 16'sd7, 16'sd7);
		send_item(MODE_SAMPLE, 16'sd9, 16'sd3, 16'sd7);
		drain();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			phase_kind = ph % 3;
			for (int i = 0; i < 3; i++) begin
				a = rand_sample(phase_kind == 0 ? 0 : (phase_kind == 1 ? 1 : 2));
				b = rand_sample(phase_kind == 0 ? 0 : (phase_kind == 1 ? 1 : 2));
				lo[i] = a;
				hi[i] = b;
			end
			write_bounds(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
			write_reg(REG_CALIB_EN, 16'($urandom()));
			send_item(MODE_PRESET, 16'($urandom()), 16'($urandom()), 16'($urandom()));
			for (int k = 0; k < 300; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					send_item(MODE_PRESET, 16'($urandom()), 16'($urandom()), 16'($urandom()));
				else if (r < 7)
					send_item(MODE_RESTART, 16'($urandom()), 16'($urandom()), 16'($urandom()));
				else if (r < 9)
					send_item(MODE_UNUSED, 16'($urandom()), 16'($urandom()), 16'($urandom()));
				else begin
					kind = (r < 20) ? 0 : (r < 60 ? 1 : 2);
					send_item(MODE_SAMPLE, rand_sample(kind), rand_sample(kind),
						rand_sample(kind));
				end
			end
			drain();
		end

		if (sb.pending_vecs.size() != 0) sb.mismatches++;
		$display("Checked %0d sample results (%0d zero vectors) over six register settings,",
			sb.checked, sb.zero_vecs);
		$display("with preset loads, restarts and unused-mode transactions mixed in.");
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
